// ===== hw/rtl/bvts_pkg.sv =====
// shared types, constants and helpers for the binary voxel trilinear sampler
// no dependencies
package bvts_pkg;

    localparam int MAX_DIM   = 64;
    localparam int FRAC_W    = 16;
    localparam int COORD_W   = 18;
    localparam int UCOORD_W  = FRAC_W + 1;
    localparam int DIM_W     = 7;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 18;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int NXY_W     = 2 * IDX_W + 1;
    localparam int YT_W      = 2 * IDX_W;
    localparam int SCALE_W   = 16;
    localparam int DENS_W    = 24;
    localparam int VQ_W      = DIM_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW   = $clog2(FIFO_DEPTH);

    localparam logic [UCOORD_W-1:0] ONE_FX = UCOORD_W'(1) << FRAC_W;
    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2,
        REG_SCALE  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    // classified item passed from the front end to the back end
    typedef struct packed {
        logic                is_query;
        logic                in_unit;
        logic [UCOORD_W-1:0] cx;
        logic [UCOORD_W-1:0] cy;
        logic [UCOORD_W-1:0] cz;
        logic [ADDR_W-1:0]   widx;
        logic                wbit;
    } item_t;

    typedef struct packed {
        logic [DIM_W-1:0] nx;
        logic [DIM_W-1:0] ny;
        logic [DIM_W-1:0] nz;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

    // zero acts as one, anything above the grid limit saturates
    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] r;
        if (n == '0) begin
            r = DIM_W'(1);
        end else if (n > MAX_DIM_V) begin
            r = MAX_DIM_V;
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bvts_front.sv =====
// front end: input register and query classification (inside test)
// depends on bvts_pkg
module bvts_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_mode,
    input  logic [bvts_pkg::COORD_W-1:0] in_cx,
    input  logic [bvts_pkg::COORD_W-1:0] in_cy,
    input  logic [bvts_pkg::COORD_W-1:0] in_cz,
    input  logic [bvts_pkg::ADDR_W-1:0]  in_idx,
    input  logic                         in_bit,
    output logic                         push,
    output bvts_pkg::item_t              push_item,
    input  logic                         q_full
);
    import bvts_pkg::*;

    logic  f_valid_reg, f_valid_next;
    item_t f_item_reg;
    logic  fire;

    // inside the closed box: 0 <= c <= ONE
    function automatic logic in_box(input logic [COORD_W-1:0] c);
        return !c[COORD_W-1] && ($signed(c) <= $signed({1'b0, ONE_FX}));
    endfunction

    assign in_ready     = !f_valid_reg || !q_full;
    assign fire         = in_valid && in_ready;
    assign push         = f_valid_reg && !q_full;
    assign push_item    = f_item_reg;
    assign f_valid_next = fire || (f_valid_reg && !push);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            f_item_reg.is_query <= (in_mode == MODE_QUERY);
            f_item_reg.in_unit  <= in_box(in_cx) && in_box(in_cy) && in_box(in_cz);
            f_item_reg.cx       <= in_cx[UCOORD_W-1:0];
            f_item_reg.cy       <= in_cy[UCOORD_W-1:0];
            f_item_reg.cz       <= in_cz[UCOORD_W-1:0];
            f_item_reg.widx     <= in_idx;
            f_item_reg.wbit     <= in_bit;
        end
    end

endmodule

// ===== hw/rtl/bvts_fifo.sv =====
// short item queue between front and back end
// depends on bvts_pkg
module bvts_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bvts_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output bvts_pkg::item_t head
);
    import bvts_pkg::*;

    item_t                ent_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic                 do_pop;

    assign full      = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = ent_reg[rp_reg];
    assign do_pop    = pop && not_empty;

    always_comb begin
        wp_next  = push ? wp_reg + FIFO_AW'(1) : wp_reg;
        rp_next  = do_pop ? rp_reg + FIFO_AW'(1) : rp_reg;
        cnt_next = cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/bvts_back.sv =====
// back end: axis split, address build, replicated voxel store, blend, scale
// depends on bvts_pkg
module bvts_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bvts_pkg::cfg_t              cfg,
    input  logic                        q_not_empty,
    input  bvts_pkg::item_t             q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bvts_pkg::DENS_W-1:0] out_density,
    output logic                        out_inside
);
    import bvts_pkg::*;

    localparam int PROD_W = 2 * UCOORD_W + 1;
    localparam int SP_W   = UCOORD_W + SCALE_W;

    logic adv;
    logic [DIM_W-1:0] nx, ny, nz;
    logic [NXY_W-1:0] nxy_reg;

    // stage 1: split axis
    logic             v1_reg;
    logic             q1_reg, in1_reg, wb1_reg;
    logic [ADDR_W-1:0] wi1_reg;
    logic [IDX_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg, z0_reg, z1_reg;
    logic [FRAC_W-1:0] fx1_reg, fy1_reg, fz1_reg;

    // stage 2: row / plane offsets
    logic              v2_reg, q2_reg, in2_reg, wb2_reg;
    logic [ADDR_W-1:0] wi2_reg;
    logic [ADDR_W-1:0] zt_reg [2];
    logic [YT_W-1:0]   yt_reg [2];
    logic [IDX_W-1:0]  xs_reg [2];
    logic [FRAC_W-1:0] fx2_reg, fy2_reg, fz2_reg;

    // stage 3: corner addresses
    logic              v3_reg, q3_reg, in3_reg, wb3_reg;
    logic [ADDR_W-1:0] wi3_reg;
    logic [ADDR_W-1:0] ad_reg [8];
    logic [FRAC_W-1:0] fx3_reg, fy3_reg, fz3_reg;

    // stage 4: store access
    logic              v4_reg, q4_reg, in4_reg;
    logic [7:0]        b_reg;
    logic [FRAC_W-1:0] fx4_reg, fy4_reg, fz4_reg;

    // stage 5: x blend
    logic              v5_reg, q5_reg, in5_reg;
    logic [UCOORD_W-1:0] a_reg [4];
    logic [FRAC_W-1:0] fy5_reg, fz5_reg;

    // stage 6: y blend
    logic              v6_reg, q6_reg, in6_reg;
    logic [UCOORD_W-1:0] d0_reg, d1_reg;
    logic [FRAC_W-1:0] fz6_reg;

    // stage 7: z blend
    logic              v7_reg, q7_reg, in7_reg;
    logic [UCOORD_W-1:0] d_reg;

    // output register
    logic              ov_reg, ov_next;
    logic [DENS_W-1:0] od_reg;
    logic              oi_reg;
    logic [SP_W-1:0]   sp;

    // one copy of the store per corner, all written together
    logic mem0 [DEPTH];
    logic mem1 [DEPTH];
    logic mem2 [DEPTH];
    logic mem3 [DEPTH];
    logic mem4 [DEPTH];
    logic mem5 [DEPTH];
    logic mem6 [DEPTH];
    logic mem7 [DEPTH];

    assign nx = eff_size(cfg.nx);
    assign ny = eff_size(cfg.ny);
    assign nz = eff_size(cfg.nz);

    assign adv   = !ov_reg || out_ready;
    assign q_pop = adv;

    always_ff @(posedge aclk) begin
        nxy_reg <= NXY_W'(nx) * NXY_W'(ny);
    end

    // neighbour indices and fraction for one axis
    typedef struct packed {
        logic [IDX_W-1:0]  i0;
        logic [IDX_W-1:0]  i1;
        logic [FRAC_W-1:0] fr;
    } split_t;

    function automatic split_t split_axis(input logic [UCOORD_W-1:0] c,
                                          input logic [DIM_W-1:0] n);
        logic [UCOORD_W+DIM_W-1:0] v;
        logic [VQ_W-1:0]           vq;
        logic [VQ_W-1:0]           vm;
        logic [VQ_W-1:0]           nm1;
        split_t                    s;
        v   = (UCOORD_W+DIM_W)'(c) * (UCOORD_W+DIM_W)'(n)
            + (UCOORD_W+DIM_W)'(ONE_FX >> 1);
        vq  = v[FRAC_W +: VQ_W];
        nm1 = n - VQ_W'(1);
        vm  = vq - VQ_W'(1);
        s.fr = v[FRAC_W-1:0];
        s.i1 = (vq > nm1) ? nm1[IDX_W-1:0] : vq[IDX_W-1:0];
        if (vq == '0) begin
            s.i0 = '0;
        end else begin
            s.i0 = (vm > nm1) ? nm1[IDX_W-1:0] : vm[IDX_W-1:0];
        end
        return s;
    endfunction

    split_t sx, sy, sz;
    assign sx = split_axis(q_head.cx, nx);
    assign sy = split_axis(q_head.cy, ny);
    assign sz = split_axis(q_head.cz, nz);

    function automatic logic [UCOORD_W-1:0] lerp(input logic [FRAC_W-1:0] f,
                                                 input logic [UCOORD_W-1:0] a,
                                                 input logic [UCOORD_W-1:0] b);
        logic [PROD_W-1:0] s;
        s = PROD_W'(a) * PROD_W'(ONE_FX - UCOORD_W'(f)) + PROD_W'(b) * PROD_W'(f);
        return s[FRAC_W +: UCOORD_W];
    endfunction

    assign sp = SP_W'(d_reg) * SP_W'(cfg.scale);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= q_not_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            ov_reg <= ov_next;
        end
    end

    assign ov_next = v7_reg && q7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1
            q1_reg  <= q_head.is_query;
            in1_reg <= q_head.in_unit;
            wi1_reg <= q_head.widx;
            wb1_reg <= q_head.wbit;
            x0_reg  <= sx.i0;
            x1_reg  <= sx.i1;
            y0_reg  <= sy.i0;
            y1_reg  <= sy.i1;
            z0_reg  <= sz.i0;
            z1_reg  <= sz.i1;
            fx1_reg <= sx.fr;
            fy1_reg <= sy.fr;
            fz1_reg <= sz.fr;
            // stage 2
            q2_reg    <= q1_reg;
            in2_reg   <= in1_reg;
            wi2_reg   <= wi1_reg;
            wb2_reg   <= wb1_reg;
            zt_reg[0] <= ADDR_W'(z0_reg) * ADDR_W'(nxy_reg);
            zt_reg[1] <= ADDR_W'(z1_reg) * ADDR_W'(nxy_reg);
            yt_reg[0] <= YT_W'(y0_reg) * YT_W'(nx);
            yt_reg[1] <= YT_W'(y1_reg) * YT_W'(nx);
            xs_reg[0] <= x0_reg;
            xs_reg[1] <= x1_reg;
            fx2_reg   <= fx1_reg;
            fy2_reg   <= fy1_reg;
            fz2_reg   <= fz1_reg;
            // stage 3
            q3_reg  <= q2_reg;
            in3_reg <= in2_reg;
            wi3_reg <= wi2_reg;
            wb3_reg <= wb2_reg;
            for (int k = 0; k < 8; k++) begin
                ad_reg[k] <= zt_reg[k/4] + ADDR_W'(yt_reg[(k/2)%2])
                           + ADDR_W'(xs_reg[k%2]);
            end
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
            fz3_reg <= fz2_reg;
            // stage 4 side data
            q4_reg  <= q3_reg;
            in4_reg <= in3_reg;
            fx4_reg <= fx3_reg;
            fy4_reg <= fy3_reg;
            fz4_reg <= fz3_reg;
            // stage 5
            q5_reg  <= q4_reg;
            in5_reg <= in4_reg;
            for (int j = 0; j < 4; j++) begin
                a_reg[j] <= (b_reg[2*j]   ? (ONE_FX - UCOORD_W'(fx4_reg)) : '0)
                          + (b_reg[2*j+1] ? UCOORD_W'(fx4_reg) : '0);
            end
            fy5_reg <= fy4_reg;
            fz5_reg <= fz4_reg;
            // stage 6
            q6_reg  <= q5_reg;
            in6_reg <= in5_reg;
            d0_reg  <= lerp(fy5_reg, a_reg[0], a_reg[1]);
            d1_reg  <= lerp(fy5_reg, a_reg[2], a_reg[3]);
            fz6_reg <= fz5_reg;
            // stage 7
            q7_reg  <= q6_reg;
            in7_reg <= in6_reg;
            d_reg   <= lerp(fz6_reg, d0_reg, d1_reg);
            // output
            od_reg  <= in7_reg ? sp[FRAC_W-8 +: DENS_W] : '0;
            oi_reg  <= in7_reg;
        end
    end

    // store: writes and reads in the same stage keep item order
    logic wr_en;
    assign wr_en = adv && v3_reg && !q3_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem0[wi3_reg] <= wb3_reg;
            mem1[wi3_reg] <= wb3_reg;
            mem2[wi3_reg] <= wb3_reg;
            mem3[wi3_reg] <= wb3_reg;
            mem4[wi3_reg] <= wb3_reg;
            mem5[wi3_reg] <= wb3_reg;
            mem6[wi3_reg] <= wb3_reg;
            mem7[wi3_reg] <= wb3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_reg[0] <= mem0[ad_reg[0]];
            b_reg[1] <= mem1[ad_reg[1]];
            b_reg[2] <= mem2[ad_reg[2]];
            b_reg[3] <= mem3[ad_reg[3]];
            b_reg[4] <= mem4[ad_reg[4]];
            b_reg[5] <= mem5[ad_reg[5]];
            b_reg[6] <= mem6[ad_reg[6]];
            b_reg[7] <= mem7[ad_reg[7]];
        end
    end

    assign out_valid   = ov_reg;
    assign out_density = od_reg;
    assign out_inside  = oi_reg;

endmodule

// ===== hw/rtl/binary_voxel_trilinear_sampler_top.sv =====
// path: front register, queue, split, offsets, addresses, store, blend, output register
// one item per cycle unless output stalls; eight store replicas give the eight corner reads
// write items flow through the same pipeline and produce no result
// reset (aresetn, synchronous, active low) clears handshake and pipeline control
// and config registers; the voxel store is not cleared and reads undefined until written
// depends on bvts_pkg, bvts_front, bvts_fifo, bvts_back
module binary_voxel_trilinear_sampler_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // coord_x, coord_y, coord_z, voxel_index, voxel_bit, pad
    input  logic        s_tuser,   // mode
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // density_value
    output logic        m_tuser,   // inside_res
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bvts_pkg::*;

    cfg_t  cfg_reg;
    logic  push, q_full, q_pop, q_not_empty;
    item_t push_item, q_head;

    // config registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nx    <= DIM_W'(1);
            cfg_reg.ny    <= DIM_W'(1);
            cfg_reg.nz    <= DIM_W'(1);
            cfg_reg.scale <= SCALE_W'(256);
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_SIZE_X: cfg_reg.nx    <= cfg_data[DIM_W-1:0];
                REG_SIZE_Y: cfg_reg.ny    <= cfg_data[DIM_W-1:0];
                REG_SIZE_Z: cfg_reg.nz    <= cfg_data[DIM_W-1:0];
                REG_SCALE:  cfg_reg.scale <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // front end: register and classify
    bvts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_cx     (s_tdata[17:0]),
        .in_cy     (s_tdata[35:18]),
        .in_cz     (s_tdata[53:36]),
        .in_idx    (s_tdata[71:54]),
        .in_bit    (s_tdata[72]),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    // queue decouples front from back
    bvts_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back end: split, address, store, blend, scale, output register
    bvts_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_density (m_tdata),
        .out_inside  (m_tuser)
    );

endmodule

// ===== verif/bvts_checker.sv =====
// result checker for the binary voxel trilinear sampler: watches the item, result and
// config channels, predicts each query result and compares it; depends on bvts_pkg
`timescale 1ns / 1ps
module bvts_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          pending,
    output int          errors
);
    import bvts_pkg::*;

    typedef struct packed {
        logic [DENS_W-1:0] density;
        logic              in_unit;
    } density_t;

    bit               occupancy [0:DEPTH-1];
    logic [DIM_W-1:0] grid_nx, grid_ny, grid_nz;
    logic [15:0]      dens_scale;
    density_t         expected_densities [$];

    function automatic int grid_dim(input logic [DIM_W-1:0] n);
        if (n == 0) return 1;
        if (n > MAX_DIM) return MAX_DIM;
        return int'(n);
    endfunction

    function automatic density_t sample_density(input logic signed [17:0] px,
                                                input logic signed [17:0] py,
                                                input logic signed [17:0] pz);
        longint   c [3];
        int       n [3];
        int       lo [3];
        int       hi [3];
        longint   fr [3];
        longint   v, fl, a [4], d0, d1, d;
        int       xi, yi, zi, k;
        density_t r;
        c[0] = px;
        c[1] = py;
        c[2] = pz;
        n[0] = grid_dim(grid_nx);
        n[1] = grid_dim(grid_ny);
        n[2] = grid_dim(grid_nz);
        r = '0;
        for (int i = 0; i < 3; i++) begin
            if (c[i] < 0 || c[i] > 65536) return r;
        end
        for (int i = 0; i < 3; i++) begin
            v     = c[i] * n[i] + 32768;
            fl    = (v >>> 16) - 1;
            fr[i] = v & 65535;
            lo[i] = (fl < 0) ? 0 : ((fl > n[i] - 1) ? n[i] - 1 : int'(fl));
            hi[i] = (fl + 1 > n[i] - 1) ? n[i] - 1 : int'(fl + 1);
        end
        // x blend per (y, z) corner pair: a[0]=y0z0, a[1]=y1z0, a[2]=y0z1, a[3]=y1z1
        for (k = 0; k < 4; k++) begin
            yi   = (k & 1) ? hi[1] : lo[1];
            zi   = (k & 2) ? hi[2] : lo[2];
            xi   = (zi * n[0] * n[1] + yi * n[0]) & (DEPTH - 1);
            a[k] = occupancy[(xi + lo[0]) & (DEPTH - 1)] * (65536 - fr[0])
                 + occupancy[(xi + hi[0]) & (DEPTH - 1)] * fr[0];
        end
        d0 = (a[0] * (65536 - fr[1]) + a[1] * fr[1]) >> 16;
        d1 = (a[2] * (65536 - fr[1]) + a[3] * fr[1]) >> 16;
        d  = (d0 * (65536 - fr[2]) + d1 * fr[2]) >> 16;
        r.density = DENS_W'((d * dens_scale) >> 8);
        r.in_unit = 1'b1;
        return r;
    endfunction

    always @(posedge aclk) begin
        density_t want;
        if (!aresetn) begin
            grid_nx    <= 7'd1;
            grid_ny    <= 7'd1;
            grid_nz    <= 7'd1;
            dens_scale <= 16'd256;
            expected_densities.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SIZE_X: grid_nx    <= cfg_data[DIM_W-1:0];
                    REG_SIZE_Y: grid_ny    <= cfg_data[DIM_W-1:0];
                    REG_SIZE_Z: grid_nz    <= cfg_data[DIM_W-1:0];
                    REG_SCALE:  dens_scale <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (mode_t'(s_tuser) == MODE_QUERY)
                    expected_densities.push_back(
                        sample_density(s_tdata[17:0], s_tdata[35:18], s_tdata[53:36]));
                else
                    occupancy[s_tdata[71:54]] = s_tdata[72];
            end
            if (m_tvalid && m_tready) begin
                if (expected_densities.size() == 0) begin
                    $error("unexpected result density_value=%0d inside_res=%0d",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = expected_densities.pop_front();
                    if (m_tdata !== want.density) begin
                        $error("density_value expected %0d actual %0d",
                               want.density, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.in_unit) begin
                        $error("inside_res expected %0d actual %0d", want.in_unit, m_tuser);
                        errors++;
                    end
                end
            end
        end
        pending = expected_densities.size();
    end

endmodule

// ===== verif/tb_binary_voxel_trilinear_sampler_top.sv =====
// stimulus and verdict for binary_voxel_trilinear_sampler_top; depends on bvts_pkg,
// the sampler rtl and bvts_checker, which predicts and compares the results
`timescale 1ns / 1ps
module tb_binary_voxel_trilinear_sampler_top;
    import bvts_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN      = 30;
    localparam int ITEMS      = 1950;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int pending, errors;
    int idle_cycles = 0;
    int items_sent = 0;

    // stimulus-side view of the grid, used to keep every sampled voxel written first
    bit written [0:DEPTH-1];
    int dim_x = 1, dim_y = 1, dim_z = 1;
    int burst_left = 0;
    bit steady = 0;

    always #1 aclk = ~aclk;

    binary_voxel_trilinear_sampler_top dut (.*);

    bvts_checker u_checker (.*);

    // watchdog: any handshake restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("binary_voxel_trilinear_sampler_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side backpressure: the style rotates through the four patterns below
    int rx_cycle = 0;
    int rx_hold = 0;
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle >> 8) % 4)
            0: m_tready <= 1'b1;                       // no stalls
            1: m_tready <= $urandom_range(0, 1);       // coin flip
            2: m_tready <= (rx_cycle % 7) != 0;        // periodic stall
            default: begin                             // long stall stretches
                if (rx_hold > 0) begin
                    rx_hold  <= rx_hold - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 9) == 0) rx_hold <= $urandom_range(1, 15);
                end
            end
        endcase
    end

    function automatic int clamp_dim(input int n);
        if (n == 0) return 1;
        if (n > MAX_DIM) return MAX_DIM;
        return n;
    endfunction

    // one request on the item channel, with random gaps between bursts unless steady is set
    task automatic send_request(input bit qry, input logic [17:0] cx, input logic [17:0] cy,
                                input logic [17:0] cz, input logic [17:0] vidx,
                                input bit vbit);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if (!steady) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = qry ? MODE_QUERY : MODE_WRITE;
        s_tdata  = {7'b0, vbit, vidx, cz, cy, cx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
        if (!qry) written[vidx] = 1'b1;
    endtask

    task automatic write_voxel(input int vidx, input bit vbit);
        send_request(1'b0, 18'($urandom), 18'($urandom), 18'($urandom), 18'(vidx), vbit);
    endtask

    // for an inside point, loads any of the eight neighbours not yet written; then queries
    task automatic query_point(input logic signed [17:0] cx, input logic signed [17:0] cy,
                               input logic signed [17:0] cz);
        longint c [3];
        int     n [3];
        int     lo [3], hi [3];
        longint v, fl;
        int     vidx;
        c[0] = cx;
        c[1] = cy;
        c[2] = cz;
        n[0] = clamp_dim(dim_x);
        n[1] = clamp_dim(dim_y);
        n[2] = clamp_dim(dim_z);
        if (c[0] >= 0 && c[0] <= 65536 && c[1] >= 0 && c[1] <= 65536
                && c[2] >= 0 && c[2] <= 65536) begin
            for (int i = 0; i < 3; i++) begin
                v     = c[i] * n[i] + 32768;
                fl    = (v >>> 16) - 1;
                lo[i] = (fl < 0) ? 0 : ((fl > n[i] - 1) ? n[i] - 1 : int'(fl));
                hi[i] = (fl + 1 > n[i] - 1) ? n[i] - 1 : int'(fl + 1);
            end
            for (int k = 0; k < 8; k++) begin
                vidx = (((k & 4) ? hi[2] : lo[2]) * n[0] * n[1]
                      + ((k & 2) ? hi[1] : lo[1]) * n[0]
                      + ((k & 1) ? hi[0] : lo[0])) & (DEPTH - 1);
                if (!written[vidx]) write_voxel(vidx, $urandom_range(0, 1));
            end
        end
        send_request(1'b1, cx, cy, cz, 18'($urandom), $urandom_range(0, 1));
    endtask

    task automatic write_register(input cfg_reg_t idx, input int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = 16'(value);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // let all results arrive, then give trailing write items time to leave the pipe
    task automatic wait_quiet();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic set_grid(input int nx, input int ny, input int nz, input int scale);
        wait_quiet();
        write_register(REG_SIZE_X, nx);
        write_register(REG_SIZE_Y, ny);
        write_register(REG_SIZE_Z, nz);
        write_register(REG_SCALE, scale);
        dim_x = nx;
        dim_y = ny;
        dim_z = nz;
    endtask

    // mostly inside the box, with faces, just-outside points and full-range noise
    function automatic logic [17:0] pick_coord();
        case ($urandom_range(0, 19))
            0:       return 18'd0;
            1:       return 18'd65536;
            2:       return 18'h3FFFF;
            3:       return 18'd65537;
            4, 5:    return 18'($urandom);
            default: return 18'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: faces, centre, points just outside and the field extremes
        set_grid(4, 4, 4, 256);
        write_voxel(0, 1);
        write_voxel(DEPTH - 1, 1);
        query_point(18'd0, 18'd0, 18'd0);
        query_point(18'd65536, 18'd65536, 18'd65536);
        query_point(18'd32768, 18'd32768, 18'd32768);
        query_point(18'd65535, 18'd1, 18'd8192);
        query_point(18'h3FFFF, 18'd100, 18'd100);
        query_point(18'd100, 18'd65537, 18'd100);
        query_point(18'd100, 18'd100, 18'h20000);
        query_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        query_point(18'h20000, 18'd0, 18'd0);
        set_grid(0, 0, 0, 65535);      // zero sizes act as one
        query_point(18'd0, 18'd65536, 18'd12345);
        query_point(18'd40000, 18'd20000, 18'd65536);
        set_grid(127, 127, 127, 0);    // oversize saturates at the grid limit
        query_point(18'd65536, 18'd65536, 18'd65536);
        query_point(18'd1, 18'd65535, 18'd32768);

        // random phases across grid settings, extremes first; each phase fills its
        // share of the item budget, neighbour loads included
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_grid(64, 64, 64, 65535);
                1: set_grid(127, 2, 1, 1);
                2: set_grid(1, 64, 3, 256);
                3: set_grid(0, 5, 64, 65535);
                default: set_grid($urandom_range(0, 9) ? $urandom_range(0, 12)
                                                        : $urandom_range(0, 127),
                                  $urandom_range(0, 12), $urandom_range(0, 12),
                                  $urandom_range(0, 65535));
            endcase
            steady = (ph % 3) == 2;
            while (items_sent < ITEMS * (ph + 1) / 10) begin
                if ($urandom_range(0, 3) == 0)
                    send_request(1'b0, 18'($urandom), 18'($urandom), 18'($urandom),
                                 18'($urandom), $urandom_range(0, 1));
                else
                    query_point(pick_coord(), pick_coord(), pick_coord());
            end
        end

        wait_quiet();
        if (errors == 0) begin
            $display("binary_voxel_trilinear_sampler_top verification clean");
        end else begin
            $display("binary_voxel_trilinear_sampler_top verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bvts_pkg.sv
hw/rtl/bvts_front.sv
hw/rtl/bvts_fifo.sv
hw/rtl/bvts_back.sv
hw/rtl/binary_voxel_trilinear_sampler_top.sv
verif/bvts_checker.sv
verif/tb_binary_voxel_trilinear_sampler_top.sv
